### rtl/forest_fire_automaton_step_unit_macros.svh
// Assertion macros for the forest-fire generation step unit.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef FOREST_FIRE_AUTOMATON_STEP_UNIT_MACROS_SVH
`define FOREST_FIRE_AUTOMATON_STEP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define FFAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define FFAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFAS_ASSERT(lbl, prop, msg)
`define FFAS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/ffas_pkg.sv
// Shared types and constants for the forest-fire generation step unit.
// No dependencies.
`default_nettype none

package ffas_pkg;

  localparam int STATE_W    = 3;
  localparam int DRAW_W     = 7;
  localparam int PCT_W      = 7;
  localparam int COLS_CFG_W = 7;
  localparam int ROWS_CFG_W = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_IDX_W  = 10;
  localparam int COL_IDX_W  = 6;

  // Cell state codes
  localparam logic [STATE_W-1:0] ST_EMPTY    = 3'd0;
  localparam logic [STATE_W-1:0] ST_TREE     = 3'd1;
  localparam logic [STATE_W-1:0] ST_NEW_FIRE = 3'd2;
  localparam logic [STATE_W-1:0] ST_FIRE     = 3'd3;
  localparam logic [STATE_W-1:0] ST_BURNT    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNITE_PERCENT = 2'd2;

  // Register reset values
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd50;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 11'd50;
  localparam logic [PCT_W-1:0]      PCT_RESET  = 7'd80;

  // Old-generation neighbourhood of the emitted cell
  typedef struct packed {
    logic [STATE_W-1:0] self_st;
    logic [STATE_W-1:0] up_st;
    logic [STATE_W-1:0] down_st;
    logic [STATE_W-1:0] left_st;
    logic [STATE_W-1:0] right_st;
    logic               up_ok;
    logic               down_ok;
    logic               left_ok;
    logic               right_ok;
  } ffas_nbr_t;

  // Ignition draws, one per direction
  typedef struct packed {
    logic [DRAW_W-1:0] up;
    logic [DRAW_W-1:0] down;
    logic [DRAW_W-1:0] left;
    logic [DRAW_W-1:0] right;
  } ffas_draws_t;

endpackage

`default_nettype wire

### rtl/ffas_line_mem.sv
// Line store: one write port, two registered read ports with write-first bypass.
// Depends on nothing outside this file.
`default_nettype none

module ffas_line_mem #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 3
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [DATA_W-1:0] rdata_a,
  output logic      [DATA_W-1:0] rdata_b
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_a_r;
  logic [DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Return the value being written when the addresses meet
  always_ff @(posedge clk) begin
    rdata_a_r <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b_r <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

### rtl/ffas_cell_update.sv
// Next-generation rule for one cell from its old neighbourhood and the draws.
// Depends on ffas_pkg.
`default_nettype none

module ffas_cell_update (
  input  wire ffas_pkg::ffas_nbr_t                 nbr,
  input  wire ffas_pkg::ffas_draws_t               draws,
  input  wire logic [ffas_pkg::PCT_W-1:0]          ignite_pct,
  output logic      [ffas_pkg::STATE_W-1:0]        new_state
);

  function automatic logic lights(input logic [ffas_pkg::STATE_W-1:0] st,
                                  input logic [ffas_pkg::DRAW_W-1:0]  draw,
                                  input logic [ffas_pkg::PCT_W-1:0]   pct);
    return ((st == ffas_pkg::ST_NEW_FIRE) || (st == ffas_pkg::ST_FIRE)) && (draw < pct);
  endfunction

  logic hit;

  always_comb begin
    hit = (nbr.up_ok    && lights(nbr.up_st,    draws.up,    ignite_pct)) ||
          (nbr.down_ok  && lights(nbr.down_st,  draws.down,  ignite_pct)) ||
          (nbr.left_ok  && lights(nbr.left_st,  draws.left,  ignite_pct)) ||
          (nbr.right_ok && lights(nbr.right_st, draws.right, ignite_pct));
    case (nbr.self_st)
      ffas_pkg::ST_NEW_FIRE: new_state = ffas_pkg::ST_FIRE;
      ffas_pkg::ST_FIRE:     new_state = ffas_pkg::ST_BURNT;
      ffas_pkg::ST_TREE:     new_state = hit ? ffas_pkg::ST_NEW_FIRE : ffas_pkg::ST_TREE;
      default:               new_state = nbr.self_st;
    endcase
  end

endmodule

`default_nettype wire

### rtl/forest_fire_automaton_step_unit.sv
// Top level of the forest-fire generation step unit: input stage, line store,
// cell update and result register. Depends on ffas_pkg, ffas_line_mem,
// ffas_cell_update and forest_fire_automaton_step_unit_macros.svh.
//
//   beat     direction  handshake           payload
//   in_*     in         in_valid/in_stall   cmd, cell_state, four ignition draws
//   out_*    out        out_valid/out_stall row_index, col_index, new_state, grid_done
//   cfg_*    in         cfg_we              cfg_index, cfg_wdata
//
// One beat a cycle sustained while out_stall is low; a result passes the input stage and then the result register.
// The pace is set by the line store: its two registered read ports are addressed
// from the next column count, so the neighbours are waiting when the beat arrives.
// Reset clears the counters and the valid flags and sets the configuration
// registers to their reset values; the line store is not cleared.
// A stall on the result side holds the input stage; beats that give no result
// (first row, early padding) still drain past a stalled output.
`default_nettype none

module forest_fire_automaton_step_unit #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_we,
  input  wire logic [ffas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ffas_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input beats
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_cmd,
  input  wire logic [ffas_pkg::STATE_W-1:0]         in_cell_state,
  input  wire logic [ffas_pkg::DRAW_W-1:0]          in_draw_up,
  input  wire logic [ffas_pkg::DRAW_W-1:0]          in_draw_down,
  input  wire logic [ffas_pkg::DRAW_W-1:0]          in_draw_left,
  input  wire logic [ffas_pkg::DRAW_W-1:0]          in_draw_right,
  // result beats
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [ffas_pkg::ROW_IDX_W-1:0]       out_row_index,
  output logic      [ffas_pkg::COL_IDX_W-1:0]       out_col_index,
  output logic      [ffas_pkg::STATE_W-1:0]         out_new_state,
  output logic                                      out_grid_done
);

`include "forest_fire_automaton_step_unit_macros.svh"

  // Column counter width indexes the line store; row counter must reach the flush row
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int NCW = (CW + 1 > ffas_pkg::COLS_CFG_W) ? CW + 1 : ffas_pkg::COLS_CFG_W;
  localparam int NRW = (RW > ffas_pkg::ROWS_CFG_W) ? RW : ffas_pkg::ROWS_CFG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ffas_pkg::COLS_CFG_W-1:0] cfg_cols_r;
  logic [ffas_pkg::ROWS_CFG_W-1:0] cfg_rows_r;
  logic [ffas_pkg::PCT_W-1:0]      cfg_pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= ffas_pkg::COLS_RESET;
      cfg_rows_r <= ffas_pkg::ROWS_RESET;
      cfg_pct_r  <= ffas_pkg::PCT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ffas_pkg::CFG_COLS_IN_USE:    cfg_cols_r <= cfg_wdata[ffas_pkg::COLS_CFG_W-1:0];
        ffas_pkg::CFG_ROWS_IN_USE:    cfg_rows_r <= cfg_wdata[ffas_pkg::ROWS_CFG_W-1:0];
        ffas_pkg::CFG_IGNITE_PERCENT: cfg_pct_r  <= cfg_wdata[ffas_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size into the range the store and counters can hold
  logic [NCW-1:0] cols_ext;
  logic [NCW-1:0] ncols;
  logic [NRW-1:0] rows_ext;
  logic [NRW-1:0] nrows;

  always_comb begin
    cols_ext = NCW'(cfg_cols_r);
    if (cols_ext < NCW'(2)) begin
      ncols = NCW'(2);
    end else if (cols_ext > NCW'(MAX_COLS)) begin
      ncols = NCW'(MAX_COLS);
    end else begin
      ncols = cols_ext;
    end
    rows_ext = NRW'(cfg_rows_r);
    if (rows_ext < NRW'(2)) begin
      nrows = NRW'(2);
    end else if (rows_ext > NRW'(MAX_ROWS)) begin
      nrows = NRW'(MAX_ROWS);
    end else begin
      nrows = rows_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage
  // ---------------------------------------------------------------------------
  logic                          s1_valid_r;
  logic                          s1_cmd_r;
  logic [ffas_pkg::STATE_W-1:0]  s1_cell_r;
  ffas_pkg::ffas_draws_t         s1_draws_r;
  logic                          s1_go;
  logic                          s1_load;
  logic                          s1_valid_nxt;

  assign in_stall     = s1_valid_r && !s1_go;
  assign s1_load      = in_valid && !in_stall;
  assign s1_valid_nxt = s1_load || (s1_valid_r && !s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cmd_r         <= in_cmd;
      s1_cell_r        <= in_cell_state;
      s1_draws_r.up    <= in_draw_up;
      s1_draws_r.down  <= in_draw_down;
      s1_draws_r.left  <= in_draw_left;
      s1_draws_r.right <= in_draw_right;
    end
  end

  // ---------------------------------------------------------------------------
  // Raster position of the beat in the input stage
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_cnt_r;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_cnt_r;
  logic [RW-1:0] row_nxt;
  logic [RW-1:0] emit_row;
  logic          s1_flush;
  logic          s1_ignore;
  logic          s1_last_col;
  logic          s1_produce;
  logic          s1_step;
  logic          out_free;

  assign s1_flush    = NRW'(row_cnt_r) >= nrows;
  assign s1_ignore   = !s1_flush && s1_cmd_r;
  assign s1_last_col = (NCW'(col_cnt_r) + NCW'(1)) >= ncols;
  assign s1_produce  = !s1_ignore && (row_cnt_r != '0);
  assign emit_row    = row_cnt_r - RW'(1);

  // Drop beats that make no result even while the output is stalled
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid_r && (out_free || !s1_produce);
  assign s1_step  = s1_go && !s1_ignore;

  always_comb begin
    col_nxt = col_cnt_r;
    row_nxt = row_cnt_r;
    if (s1_step) begin
      if (s1_last_col) begin
        col_nxt = '0;
        row_nxt = s1_flush ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one memory per row parity. Port A reads the current column,
  // port B the column to the right, both from the next raster position.
  // ---------------------------------------------------------------------------
  logic                         wr_en;
  logic [ffas_pkg::STATE_W-1:0] even_a;
  logic [ffas_pkg::STATE_W-1:0] even_b;
  logic [ffas_pkg::STATE_W-1:0] odd_a;
  logic [ffas_pkg::STATE_W-1:0] odd_b;
  logic [CW-1:0]                rd_addr_b;

  assign wr_en     = s1_step && !s1_flush;
  assign rd_addr_b = col_nxt + CW'(1);

  ffas_line_mem #(
    .ADDR_W (CW),
    .DATA_W (ffas_pkg::STATE_W)
  ) u_even_line (
    .clk     (clk),
    .we      (wr_en && !row_cnt_r[0]),
    .waddr   (col_cnt_r),
    .wdata   (s1_cell_r),
    .raddr_a (col_nxt),
    .raddr_b (rd_addr_b),
    .rdata_a (even_a),
    .rdata_b (even_b)
  );

  ffas_line_mem #(
    .ADDR_W (CW),
    .DATA_W (ffas_pkg::STATE_W)
  ) u_odd_line (
    .clk     (clk),
    .we      (wr_en && row_cnt_r[0]),
    .waddr   (col_cnt_r),
    .wdata   (s1_cell_r),
    .raddr_a (col_nxt),
    .raddr_b (rd_addr_b),
    .rdata_a (odd_a),
    .rdata_b (odd_b)
  );

  // The emitted row has the opposite parity of the incoming row; the row above
  // it shares the incoming row's slots, still holding its old values.
  logic [ffas_pkg::STATE_W-1:0] left_r;
  ffas_pkg::ffas_nbr_t          nbr;
  logic [ffas_pkg::STATE_W-1:0] new_state;

  always_comb begin
    nbr.self_st  = row_cnt_r[0] ? even_a : odd_a;
    nbr.right_st = row_cnt_r[0] ? even_b : odd_b;
    nbr.up_st    = row_cnt_r[0] ? odd_a  : even_a;
    nbr.left_st  = left_r;
    nbr.down_st  = s1_cell_r;
    nbr.up_ok    = row_cnt_r > RW'(1);
    nbr.down_ok  = !s1_flush;
    nbr.left_ok  = col_cnt_r != '0;
    nbr.right_ok = !s1_last_col;
  end

  // Hold the emitted cell's old state as the next column's left neighbour
  always_ff @(posedge clk) begin
    if (s1_step) begin
      left_r <= nbr.self_st;
    end
  end

  ffas_cell_update u_cell_update (
    .nbr        (nbr),
    .draws      (s1_draws_r),
    .ignite_pct (cfg_pct_r),
    .new_state  (new_state)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [ffas_pkg::ROW_IDX_W-1:0] out_row_r;
  logic [ffas_pkg::COL_IDX_W-1:0] out_col_r;
  logic [ffas_pkg::STATE_W-1:0]   out_state_r;
  logic                           out_done_r;
  logic                           out_load;

  assign out_load      = s1_go && s1_produce;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r   <= ffas_pkg::ROW_IDX_W'(emit_row);
      out_col_r   <= ffas_pkg::COL_IDX_W'(col_cnt_r);
      out_state_r <= new_state;
      out_done_r  <= s1_flush && s1_last_col;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_col_index = out_col_r;
  assign out_new_state = out_state_r;
  assign out_grid_done = out_done_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FFAS_ASSERT(a_no_result_overwrite, !(out_load && out_valid_r && out_stall), "result overwritten while stalled")
  `FFAS_ASSERT(a_flush_end_rewinds, (s1_step && s1_flush && s1_last_col) |=> (row_cnt_r == '0 && col_cnt_r == '0), "counters not rewound after flush row")
  `FFAS_ASSERT(a_stall_needs_item, in_stall |-> s1_valid_r, "input stalled with empty input stage")
  `FFAS_ASSERT_ALWAYS(a_reset_clears_valid, !rst_n |=> (!s1_valid_r && !out_valid_r), "valid flags survive reset")

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking bench for forest_fire_automaton_step_unit: streams grids in raster order
// and predicts each next-generation cell. Needs ffas_pkg and the block's RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffas_pkg::*;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 1024;
  localparam int CELL_TARGET = 1950;
  localparam int CALM_FROM   = 1700;
  localparam int QUIET_LIMIT = 2000;
  localparam int LOG_LIMIT   = 40;

  // One input beat and one result beat, at the block's widths
  typedef struct packed {
    logic               cmd;
    logic [STATE_W-1:0] state;
    ffas_draws_t        draws;
  } cell_beat_t;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [COL_IDX_W-1:0] col;
    logic [STATE_W-1:0]   state;
    logic                 done;
  } cell_update_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_COLS_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic [STATE_W-1:0] in_cell_state = ST_EMPTY;
  logic [DRAW_W-1:0]  in_draw_up = '0;
  logic [DRAW_W-1:0]  in_draw_down = '0;
  logic [DRAW_W-1:0]  in_draw_left = '0;
  logic [DRAW_W-1:0]  in_draw_right = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ROW_IDX_W-1:0] out_row_index;
  logic [COL_IDX_W-1:0] out_col_index;
  logic [STATE_W-1:0]   out_new_state;
  logic                 out_grid_done;

  forest_fire_automaton_step_unit #(
    .MAX_COLS(GRID_COLS),
    .MAX_ROWS(GRID_ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_cell_state (in_cell_state),
    .in_draw_up    (in_draw_up),
    .in_draw_down  (in_draw_down),
    .in_draw_left  (in_draw_left),
    .in_draw_right (in_draw_right),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_col_index (out_col_index),
    .out_new_state (out_new_state),
    .out_grid_done (out_grid_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the two-row line store, the raster counters and the
  // three registers. Advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0] forest_rows [0:2*GRID_COLS-1];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned cols_reg = COLS_RESET;
  int unsigned rows_reg = ROWS_RESET;
  int unsigned pct_reg  = PCT_RESET;

  cell_beat_t   pending_cells[$];
  cell_update_t expected_updates[$];
  int unsigned  cells_queued = 0;
  int unsigned  mismatches = 0;

  // Idling control, set per phase by the stimulus process
  bit          calm = 1'b0;
  int unsigned gap_odds = 8;
  int unsigned stall_odds = 8;

  initial begin
    for (int i = 0; i < 2*GRID_COLS; i++) forest_rows[i] = ST_EMPTY;
  end

  function automatic int unsigned clamp_cols(input int unsigned v);
    return (v < 2) ? 2 : (v > GRID_COLS) ? GRID_COLS : v;
  endfunction

  function automatic int unsigned clamp_rows(input int unsigned v);
    return (v < 2) ? 2 : (v > GRID_ROWS) ? GRID_ROWS : v;
  endfunction

  function automatic int unsigned slot_of(input int unsigned r, input int unsigned c);
    return (r % 2) * GRID_COLS + (c % GRID_COLS);
  endfunction

  // A neighbour lights a tree when it is on fire and its draw falls under the percent
  function automatic bit catches(input logic [STATE_W-1:0] nbr, input logic [DRAW_W-1:0] draw);
    return (nbr == ST_NEW_FIRE || nbr == ST_FIRE) && (draw < pct_reg);
  endfunction

  task automatic burn_step(input cell_beat_t b, output bit emits, output cell_update_t u);
    int unsigned nc, nr, c, r, er;
    bit flush, last_col, hit;
    logic [STATE_W-1:0] self_st, ns;
    nc = clamp_cols(cols_reg);
    nr = clamp_rows(rows_reg);
    flush = row_pos >= nr;
    emits = 1'b0;
    u = '0;
    // early padding: drop without touching anything
    if (!flush && b.cmd) return;
    c = col_pos;
    r = row_pos;
    // a column at or past the last one closes the row
    last_col = (c + 1) >= nc;
    if (r > 0) begin
      er = r - 1;
      self_st = forest_rows[slot_of(er, c)];
      ns = self_st;
      if (self_st == ST_NEW_FIRE) begin
        ns = ST_FIRE;
      end else if (self_st == ST_FIRE) begin
        ns = ST_BURNT;
      end else if (self_st == ST_TREE) begin
        hit = 1'b0;
        if (er > 0 && catches(forest_rows[slot_of(er - 1, c)], b.draws.up)) hit = 1'b1;
        // the flush row has no cell below
        if (!flush && catches(b.state, b.draws.down)) hit = 1'b1;
        if (c > 0 && catches(forest_rows[slot_of(er, c - 1)], b.draws.left)) hit = 1'b1;
        if (!last_col && catches(forest_rows[slot_of(er, c + 1)], b.draws.right)) hit = 1'b1;
        if (hit) ns = ST_NEW_FIRE;
      end
      u.row   = er[ROW_IDX_W-1:0];
      u.col   = c[COL_IDX_W-1:0];
      u.state = ns;
      u.done  = flush && last_col;
      emits   = 1'b1;
    end
    if (!flush) forest_rows[slot_of(r, c)] = b.state;
    if (last_col) begin
      col_pos = 0;
      row_pos = flush ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= LOG_LIMIT) $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: predict on every accepted beat, then load the next one from
  // the pending queue unless an idle burst is running. A stalled beat is held.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(posedge clk) begin : cell_driver
    cell_beat_t   seen, nxt;
    cell_update_t upd;
    bit           emits;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        seen.cmd         = in_cmd;
        seen.state       = in_cell_state;
        seen.draws.up    = in_draw_up;
        seen.draws.down  = in_draw_down;
        seen.draws.left  = in_draw_left;
        seen.draws.right = in_draw_right;
        burn_step(seen, emits, upd);
        if (emits) expected_updates.insert(expected_updates.size(), upd);
      end
      // only move on once the current beat is gone or there was none
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          gap_left = $urandom_range(1, 18) - 1;
          in_valid <= 1'b0;
        end else if (pending_cells.size() != 0) begin
          nxt = pending_cells.pop_front();
          in_cmd        <= nxt.cmd;
          in_cell_state <= nxt.state;
          in_draw_up    <= nxt.draws.up;
          in_draw_down  <= nxt.draws.down;
          in_draw_left  <= nxt.draws.left;
          in_draw_right <= nxt.draws.right;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted beat with the oldest expectation,
  // raise stall in random bursts, and watch for a hung handshake.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin : update_monitor
    cell_update_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      quiet_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_updates.size() == 0) begin
          flag_mismatch($sformatf("unexpected result row %0d col %0d state %0d",
                                  out_row_index, out_col_index, out_new_state));
        end else begin
          want = expected_updates.pop_front();
          if (out_row_index !== want.row)
            flag_mismatch($sformatf("row_index got %0d want %0d", out_row_index, want.row));
          if (out_col_index !== want.col)
            flag_mismatch($sformatf("col_index got %0d want %0d (row %0d)",
                                    out_col_index, want.col, want.row));
          if (out_new_state !== want.state)
            flag_mismatch($sformatf("new_state got %0d want %0d at (%0d,%0d)",
                                    out_new_state, want.state, want.row, want.col));
          if (out_grid_done !== want.done)
            flag_mismatch($sformatf("grid_done got %0b want %0b at (%0d,%0d)",
                                    out_grid_done, want.done, want.row, want.col));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      // watchdog: reset on any beat on either side
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [DRAW_W-1:0] rand_draw();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return DRAW_W'($urandom_range(0, 127));
    if (roll == 1) begin
      case ($urandom_range(0, 3))
        0: return 7'd0;
        1: return 7'd99;
        2: return 7'd100;
        default: return 7'd127;
      endcase
    end
    return DRAW_W'($urandom_range(0, 99));
  endfunction

  // Lean towards trees and fire so that ignition happens often
  function automatic logic [STATE_W-1:0] rand_state();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return ST_TREE;
    if (roll < 55) return ST_NEW_FIRE;
    if (roll < 70) return ST_FIRE;
    if (roll < 82) return ST_EMPTY;
    if (roll < 92) return ST_BURNT;
    return STATE_W'($urandom_range(5, 7));
  endfunction

  function automatic cell_beat_t random_cell();
    cell_beat_t b;
    b.cmd         = 1'b0;
    b.state       = rand_state();
    b.draws.up    = rand_draw();
    b.draws.down  = rand_draw();
    b.draws.left  = rand_draw();
    b.draws.right = rand_draw();
    return b;
  endfunction

  function automatic cell_beat_t beat_of(input logic cmd, input logic [STATE_W-1:0] st,
                                         input int unsigned up, input int unsigned dn,
                                         input int unsigned lf, input int unsigned rt);
    cell_beat_t b;
    b.cmd         = cmd;
    b.state       = st;
    b.draws.up    = up[DRAW_W-1:0];
    b.draws.down  = dn[DRAW_W-1:0];
    b.draws.left  = lf[DRAW_W-1:0];
    b.draws.right = rt[DRAW_W-1:0];
    return b;
  endfunction

  // Ignored early padding is not counted towards the cell total
  task automatic push_cell(input cell_beat_t b, input bit counts);
    pending_cells.insert(pending_cells.size(), b);
    if (counts) cells_queued++;
  endtask

  // Return once everything is drained, then give the pipe time to empty of
  // beats that make no result before touching the registers
  task automatic wait_settled();
    do @(negedge clk);
    while (pending_cells.size() != 0 || in_valid || expected_updates.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_COLS_IN_USE:    cols_reg = value & 32'h7F;
      CFG_ROWS_IN_USE:    rows_reg = value & 32'h7FF;
      CFG_IGNITE_PERCENT: pct_reg  = value & 32'h7F;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_settings();
    int unsigned cols_new, rows_new, fit, roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) cols_new = $urandom_range(0, 1);
    else if (roll == 1) cols_new = $urandom_range(65, 127);
    else if (roll <= 3) cols_new = $urandom_range(30, 64);
    else cols_new = $urandom_range(2, 10);
    // widening the columns past row zero would read store entries never written
    if (row_pos != 0 && clamp_cols(cols_new) > clamp_cols(cols_reg)) cols_new = cols_reg;
    // keep a grid to at most 256 cells
    fit = 256 / clamp_cols(cols_new);
    roll = $urandom_range(0, 19);
    if (roll == 0) rows_new = $urandom_range(0, 1);
    else if (roll <= 2) rows_new = $urandom_range(2, (fit < 40) ? fit : 40);
    else rows_new = $urandom_range(2, (fit < 6) ? fit : 6);
    set_reg(CFG_COLS_IN_USE, cols_new);
    set_reg(CFG_ROWS_IN_USE, rows_new);
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 5))
        0: set_reg(CFG_IGNITE_PERCENT, 0);
        1: set_reg(CFG_IGNITE_PERCENT, 100);
        2: set_reg(CFG_IGNITE_PERCENT, 127);
        3: set_reg(CFG_IGNITE_PERCENT, $urandom_range(0, 127));
        default: set_reg(CFG_IGNITE_PERCENT, $urandom_range(0, 100));
      endcase
    end
    end_writes();
  endtask

  // Queue one grid plus its flush row. If the last phase left a grid open,
  // finish it first. Now and then cut the grid short so the next one starts
  // off the raster.
  task automatic queue_forest();
    int unsigned nc, nr, left, grid_end, total, cut;
    cell_beat_t b;
    nc = clamp_cols(cols_reg);
    nr = clamp_rows(rows_reg);
    left = 0;
    if (row_pos != 0 || col_pos != 0) begin
      left = (col_pos >= nc) ? 1 : nc - col_pos;
      if (row_pos < nr) left += (nr - row_pos - 1) * nc + nc;
    end
    grid_end = left + nr * nc;
    total = grid_end + nc;
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(left + 1, total - 1) : total;
    for (int unsigned k = 0; k < cut; k++) begin
      b = random_cell();
      // the flush row takes any cmd
      if (k >= grid_end) b.cmd = 1'($urandom_range(0, 1));
      if (k >= left && k < grid_end && $urandom_range(0, 29) == 0) begin
        push_cell(beat_of(1'b1, rand_state(), rand_draw(), rand_draw(), rand_draw(),
                          rand_draw()), 1'b0);
      end
      push_cell(b, 1'b1);
    end
  endtask

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 24;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    @(posedge clk iff rst_n);

    // Smallest grid (both sizes below the floor), every draw under 100 lights
    set_reg(CFG_COLS_IN_USE, 0);
    set_reg(CFG_ROWS_IN_USE, 0);
    set_reg(CFG_IGNITE_PERCENT, 100);
    end_writes();
    @(negedge clk);
    push_cell(beat_of(1'b0, ST_TREE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_FIRE, 127, 127, 127, 127), 1'b1);
    // early padding with all draw bits set: ignored
    push_cell(beat_of(1'b1, 3'd7, 127, 127, 127, 127), 1'b0);
    // tree above catches from the new fire below at draw 99
    push_cell(beat_of(1'b0, ST_NEW_FIRE, 0, 99, 0, 127), 1'b1);
    push_cell(beat_of(1'b0, ST_TREE, 0, 0, 0, 0), 1'b1);
    // flush row: cell_state ignored, cmd either way
    push_cell(beat_of(1'b0, ST_FIRE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b1, ST_FIRE, 100, 0, 0, 0), 1'b1);
    wait_settled();

    // Percent zero: nothing lights; states 5 to 7 pass through
    set_reg(CFG_COLS_IN_USE, 3);
    set_reg(CFG_ROWS_IN_USE, 1);
    set_reg(CFG_IGNITE_PERCENT, 0);
    end_writes();
    @(negedge clk);
    push_cell(beat_of(1'b0, 3'd5, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_TREE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, 3'd7, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_TREE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_FIRE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, 3'd6, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b1, ST_EMPTY, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b1, ST_EMPTY, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b1, ST_EMPTY, 0, 0, 0, 0), 1'b1);
    wait_settled();

    // Shrink both sizes in mid grid: the column count passes the new bound
    // and the row count reaches it, so the flush row follows at once
    set_reg(CFG_COLS_IN_USE, 4);
    set_reg(CFG_ROWS_IN_USE, 2047);
    set_reg(CFG_IGNITE_PERCENT, 127);
    end_writes();
    @(negedge clk);
    push_cell(beat_of(1'b0, ST_TREE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, 3'd6, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_FIRE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_TREE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_FIRE, 99, 99, 99, 99), 1'b1);
    push_cell(beat_of(1'b0, ST_TREE, 99, 99, 99, 99), 1'b1);
    push_cell(beat_of(1'b0, ST_TREE, 99, 127, 99, 99), 1'b1);
    wait_settled();
    set_reg(CFG_COLS_IN_USE, 2);
    set_reg(CFG_ROWS_IN_USE, 2);
    end_writes();
    @(negedge clk);
    push_cell(beat_of(1'b0, ST_EMPTY, 0, 0, 126, 0), 1'b1);
    push_cell(beat_of(1'b0, ST_TREE, 0, 0, 0, 0), 1'b1);
    push_cell(beat_of(1'b1, ST_TREE, 127, 0, 99, 0), 1'b1);

    // Random grids, sizes and percents; no idling near the end
    while (cells_queued < CELL_TARGET) begin
      wait_settled();
      if ($urandom_range(0, 2) != 0) pick_settings();
      @(negedge clk);
      calm       = cells_queued > CALM_FROM;
      gap_odds   = pick_odds();
      stall_odds = pick_odds();
      queue_forest();
    end

    wait_settled();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
